@@ hdl/aesc_pkg.sv @@
// Shared constants and GF(2^8) helpers for the AES-128 counter-mode byte stream.
package aesc_pkg;

    localparam int BLK_W   = 128;
    localparam int KEY_W   = 128;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int ROUND_W = 4;
    localparam int POS_W   = 5;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;
    localparam logic [POS_W-1:0]   POS_SPENT  = 5'd16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd3;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Round constant for rounds 1 to 10
    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/aes128_ctr_byte_stream.sv @@
// Top level of the AES-128 counter-mode byte stream cipher.
//
//  channel | valid         | stall         | payload
//  --------+---------------+---------------+-------------------------------------
//  in      | i_in_valid    | o_in_stall    | i_data_byte, i_end_of_message
//  out     | o_out_valid   | i_out_stall   | o_result_byte, o_last_out
//  cfg     | i_cfg_we      | (none)        | i_cfg_index, i_cfg_data
//
//  A word whose keystream byte is on hand reaches the output register in the cycle after it is taken.
//  Every sixteenth word (and the first after a register write) waits for a fresh block:
//  the shared round unit runs ten rounds, one per cycle, before that word is emitted.
//  Input stalls while a fresh block is generated; otherwise words stream through when the output is never stalled.
//  Reset is synchronous, active low: keys, nonce and counter clear, keystream is spent.
//  The output register holds a word until taken; input stalls while it is full and stalled.
module aes128_ctr_byte_stream (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [aesc_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                              i_end_of_message,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [aesc_pkg::BYTE_W-1:0]       o_result_byte,
    output logic                              o_last_out,
    input  logic                              i_cfg_we,
    input  logic [aesc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aesc_pkg::CFG_W-1:0]        i_cfg_data
);
    import aesc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GEN  = 2'd1;
    localparam logic [1:0] S_PEND = 2'd2;

    logic [1:0]        r_state;
    logic [63:0]       r_key_hi, r_key_lo, r_nonce_hi;
    logic [31:0]       r_nonce_lo;
    logic [63:0]       n_key_hi, n_key_lo, n_nonce_hi;
    logic [31:0]       n_nonce_lo;
    logic [BLK_W-1:0]  r_ctr;
    logic [BLK_W-1:0]  r_ks;
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_hold_byte;
    logic              r_hold_eom;
    logic              r_ov;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;

    logic              cfg_hit;
    logic              out_free;
    logic              in_acc;
    logic              core_start;
    logic              core_done;
    logic [BLK_W-1:0]  core_block;
    logic [BYTE_W-1:0] ks_byte;

    // Configuration decode: a write to any listed register restarts the stream
    always_comb begin
        n_key_hi   = r_key_hi;
        n_key_lo   = r_key_lo;
        n_nonce_hi = r_nonce_hi;
        n_nonce_lo = r_nonce_lo;
        cfg_hit    = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_HIGH: begin
                    n_key_hi = i_cfg_data;
                    cfg_hit  = 1'b1;
                end
                REG_KEY_LOW: begin
                    n_key_lo = i_cfg_data;
                    cfg_hit  = 1'b1;
                end
                REG_NONCE_HIGH: begin
                    n_nonce_hi = i_cfg_data;
                    cfg_hit    = 1'b1;
                end
                REG_NONCE_LOW: begin
                    n_nonce_lo = i_cfg_data[31:0];
                    cfg_hit    = 1'b1;
                end
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign core_start = in_acc && r_pos[POS_W-1];
    assign ks_byte    = r_ks[BLK_W-1-8*r_pos[3:0] -: 8];

    aesc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_key   ({r_key_hi, r_key_lo}),
        .i_block (r_ctr),
        .o_done  (core_done),
        .o_block (core_block)
    );

    // Control: sequencer, keystream position, output valid, config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= POS_SPENT;
            r_ov       <= 1'b0;
            r_key_hi   <= '0;
            r_key_lo   <= '0;
            r_nonce_hi <= '0;
            r_nonce_lo <= '0;
            r_ctr      <= '0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (core_start) begin
                        r_state <= S_GEN;
                    end else if (in_acc) begin
                        // keystream byte on hand: emit now
                        r_ov  <= 1'b1;
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
                S_GEN: begin
                    if (core_done) begin
                        r_pos   <= '0;
                        r_ctr   <= r_ctr + BLK_W'(1);
                        r_state <= S_PEND;
                    end
                end
                S_PEND: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_pos   <= r_pos + POS_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (cfg_hit) begin
                r_key_hi   <= n_key_hi;
                r_key_lo   <= n_key_lo;
                r_nonce_hi <= n_nonce_hi;
                r_nonce_lo <= n_nonce_lo;
                r_ctr      <= {n_nonce_hi, n_nonce_lo, 32'h0};
                r_pos      <= POS_SPENT;
            end
        end
    end

    // Payload: held word, fresh keystream, output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hold_byte <= i_data_byte;
            r_hold_eom  <= i_end_of_message;
        end
        if (core_done) begin
            r_ks <= core_block;
        end
        if (r_state == S_IDLE && in_acc && !r_pos[POS_W-1]) begin
            r_obyte <= i_data_byte ^ ks_byte;
            r_olast <= i_end_of_message;
        end else if (r_state == S_PEND && out_free) begin
            r_obyte <= r_hold_byte ^ ks_byte;
            r_olast <= r_hold_eom;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_byte = r_obyte;
    assign o_last_out    = r_olast;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN || r_state == S_PEND) |-> o_in_stall)
        else $error("input taken while a block is in flight");

    a_done_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> (r_state == S_GEN))
        else $error("cipher core finished outside block generation");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SPENT)
        else $error("keystream position out of range");

    a_pend_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEND && out_free) |=> (r_ov && r_pos == POS_W'(1)))
        else $error("first word of a fresh block not emitted");

endmodule

@@ hdl/aesc_round.sv @@
// One AES round plus the matching on-the-fly round-key step.
module aesc_round (
    input  logic [aesc_pkg::BLK_W-1:0]   i_state,
    input  logic [aesc_pkg::KEY_W-1:0]   i_rkey,
    input  logic [aesc_pkg::ROUND_W-1:0] i_round,
    output logic [aesc_pkg::BLK_W-1:0]   o_state,
    output logic [aesc_pkg::KEY_W-1:0]   o_rkey
);
    import aesc_pkg::*;

    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [7:0]  m [16];
    logic [BLK_W-1:0] mixed;
    logic [31:0] w0, w1, w2, w3, rot, sub, tw, w0n, w1n, w2n, w3n;

    // Key schedule step
    always_comb begin
        w0  = i_rkey[127:96];
        w1  = i_rkey[95:64];
        w2  = i_rkey[63:32];
        w3  = i_rkey[31:0];
        rot = {w3[23:0], w3[31:24]};
        sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        tw  = sub ^ {rcon(i_round), 24'h000000};
        w0n = w0 ^ tw;
        w1n = w1 ^ w0n;
        w2n = w2 ^ w1n;
        w3n = w3 ^ w2n;
        o_rkey = {w0n, w1n, w2n, w3n};
    end

    // SubBytes, ShiftRows, MixColumns (skipped in the last round), AddRoundKey
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[BLK_W-1-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c*4+r] = SBOX[s[((c + r) & 3) * 4 + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[c*4+0] = t[c*4+0] ^ (t[c*4+0] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3])
                       ^ xtime(t[c*4+0] ^ t[c*4+1]);
            m[c*4+1] = t[c*4+1] ^ (t[c*4+0] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3])
                       ^ xtime(t[c*4+1] ^ t[c*4+2]);
            m[c*4+2] = t[c*4+2] ^ (t[c*4+0] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3])
                       ^ xtime(t[c*4+2] ^ t[c*4+3]);
            m[c*4+3] = t[c*4+3] ^ (t[c*4+0] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3])
                       ^ xtime(t[c*4+3] ^ t[c*4+0]);
        end
        for (int i = 0; i < 16; i++) begin
            mixed[BLK_W-1-8*i -: 8] = (i_round == LAST_ROUND) ? t[i] : m[i];
        end
        o_state = mixed ^ o_rkey;
    end

endmodule

@@ hdl/aesc_core.sv @@
// Iterative AES-128 encryption core: one round per cycle through a shared round unit.
module aesc_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [aesc_pkg::KEY_W-1:0] i_key,
    input  logic [aesc_pkg::BLK_W-1:0] i_block,
    output logic                       o_done,
    output logic [aesc_pkg::BLK_W-1:0] o_block
);
    import aesc_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [ROUND_W-1:0] r_round;
    logic [BLK_W-1:0]   r_state;
    logic [KEY_W-1:0]   r_rkey;
    logic [BLK_W-1:0]   n_state;
    logic [KEY_W-1:0]   n_rkey;

    aesc_round u_round (
        .i_state (r_state),
        .i_rkey  (r_rkey),
        .i_round (r_round),
        .o_state (n_state),
        .o_rkey  (n_rkey)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_round <= ROUND_W'(1);
            end else if (r_busy) begin
                r_round <= r_round + ROUND_W'(1);
                if (r_round == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Initial AddRoundKey on start, then advance one round per cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_state <= i_block ^ i_key;
            r_rkey  <= i_key;
        end else if (r_busy) begin
            r_state <= n_state;
            r_rkey  <= n_rkey;
        end
    end

    assign o_done  = r_done;
    assign o_block = r_state;

endmodule
